// ----- design/cff_pkg.sv -----
`timescale 1ns / 1ps

package cff_pkg;

   // Fixed field widths of the item, result and register words.
   localparam int SIZE_W    = 10;
   localparam int COUNT_W   = 10;
   localparam int CLASSES_W = 5;

   // Packing modes.
   localparam logic [1:0] MODE_HARMONIC = 2'd0;
   localparam logic [1:0] MODE_VARIABLE = 2'd1;
   localparam logic [1:0] MODE_BINARY   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_REJECTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_PACK_MODE    = 2'd0;
   localparam logic [1:0] CSR_NUM_CLASSES  = 2'd1;
   localparam logic [1:0] CSR_BIN_CAPACITY = 2'd2;

   // One bin as held in the bin memory.
   typedef struct packed {
      logic [SIZE_W-1:0]  fill;
      logic [COUNT_W-1:0] count;
   } bin_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SEL   = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

endpackage

// ----- design/cff_bin_mem.sv -----
`timescale 1ns / 1ps

// Single-port-write, single-port-read bin store with a registered read.
module cff_bin_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  cff_pkg::bin_entry_type wr_data,
   input  logic [AW-1:0]          rd_addr,
   output cff_pkg::bin_entry_type rd_data
);

   cff_pkg::bin_entry_type mem [DEPTH];
   cff_pkg::bin_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cff_class_sel.sv -----
`timescale 1ns / 1ps

// Walks the size classes from the smallest limit upwards, one class a cycle
// while advance is high, and stops at the first class whose limit admits the item or at the last class.
module cff_class_sel #(
   parameter int CW = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          advance,
   input  logic [cff_pkg::SIZE_W-1:0]    item_size,
   input  logic                          binary_mode,
   input  logic [cff_pkg::CLASSES_W-1:0] classes,
   input  logic [cff_pkg::SIZE_W-1:0]    capacity,
   output logic                          done,
   output logic [CW-1:0]                 class_id
);

   logic [CW-1:0] cls_ff;
   logic [CW-1:0] cls_in;
   logic [cff_pkg::CLASSES_W-1:0] cls_wide;
   logic [3:0]  steps;
   logic [14:0] scaled_mul;
   logic [24:0] scaled_shift;
   logic [24:0] scaled;
   logic        admits;
   logic        last_class;

   always_comb begin
      cls_wide     = cff_pkg::CLASSES_W'(cls_ff);
      steps        = 4'(classes - cls_wide - cff_pkg::CLASSES_W'(1));
      scaled_mul   = 15'(item_size) * 15'({1'b0, steps} + 5'd1);
      scaled_shift = 25'(item_size) << steps;
      scaled       = binary_mode ? scaled_shift : 25'(scaled_mul);
      admits       = scaled <= 25'(capacity);
      last_class   = (cls_wide + cff_pkg::CLASSES_W'(1)) >= classes;
      done         = admits || last_class;
      cls_in       = cls_ff;
      if (load) begin
         cls_in = '0;
      end else if (advance && !done) begin
         cls_in = cls_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff <= '0;
      end else begin
         cls_ff <= cls_in;
      end
   end

   assign class_id = cls_ff;

endmodule

// ----- design/class_first_fit_bin_packer_unit.sv -----
`timescale 1ns / 1ps

// Online class first-fit bin packer. A word is taken at a rising edge with start
// high and busy low; its result appears for exactly one cycle with rsp_strobe high
// and must be captured then, as the receiver cannot stall the block. A zero or
// oversize item gives its result in the cycle after acceptance. Otherwise the
// item first passes the class search, which examines one class a cycle (at most
// MAX_CLASSES classes), and then the first-fit scan, which reads the bins of the
// chosen class one by one through the bin memory's single read port and judges
// each registered word until a bin fits or the class is found full. After reset
// the block clears all MAX_CLASSES * MAX_BINS entries (512 by default) of the
// bin memory one entry a cycle, with busy held high; register writes are taken
// throughout.
module class_first_fit_bin_packer_unit #(
   parameter int MAX_CLASSES = 8,
   parameter int MAX_BINS    = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [9:0] req_item_size,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_class_index,
   output logic [5:0] rsp_bin_index,
   output logic [9:0] rsp_slot_index,
   output logic [9:0] rsp_fill_after,
   output logic       rsp_opened_new,
   output logic [6:0] rsp_bins_in_class,
   output logic [9:0] rsp_bins_total,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);

   localparam int DEPTH = MAX_CLASSES * MAX_BINS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int KW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int KCW   = $clog2(MAX_BINS + 1);
   localparam int BW    = $clog2(MAX_BINS + 1);
   localparam int TW    = $clog2(DEPTH + 1);

   // Sequencer and configuration registers.
   cff_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [1:0]     mode_ff, mode_in;
   logic [3:0]     ncls_ff, ncls_in;
   logic [9:0]     cap_ff, cap_in;
   logic [9:0]     size_ff, size_in;
   logic [CW-1:0]  cls_ff, cls_in;
   logic [KCW-1:0] rd_k_ff, rd_k_in;
   logic           ev_valid_ff, ev_valid_in;
   logic [KW-1:0]  ev_k_ff, ev_k_in;
   logic [BW-1:0]  cob_ff [MAX_CLASSES];
   logic [BW-1:0]  cob_in [MAX_CLASSES];
   logic [TW-1:0]  total_ff, total_in;

   // Result registers.
   logic       strobe_ff, strobe_in;
   logic [1:0] status_ff, status_in;
   logic [2:0] rcls_ff, rcls_in;
   logic [5:0] rbin_ff, rbin_in;
   logic [9:0] slot_ff, slot_in;
   logic [9:0] fill_ff, fill_in;
   logic       opened_ff, opened_in;
   logic [6:0] rcob_ff, rcob_in;
   logic [9:0] rtotal_ff, rtotal_in;

   // Working signals.
   logic [cff_pkg::CLASSES_W-1:0] m_eff;
   logic       mode_var;
   logic       mode_bin;
   logic       accept;
   logic       reject;
   logic       sel_done;
   logic [CW-1:0] sel_class;
   logic       issue;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] ev_addr;
   cff_pkg::bin_entry_type rd_entry;
   cff_pkg::bin_entry_type wr_entry;
   logic       wr_en;
   logic [AW-1:0] wr_addr;
   logic [10:0] sum;
   logic       fits;
   logic       found;
   logic       last_bin;
   logic       opened;
   logic [BW-1:0] cob_new;
   logic [TW-1:0] total_new;
   logic [CW+2:0] cls_ext;
   logic [KW+5:0] bin_ext;
   logic [BW+6:0] cob_ext;
   logic [BW+6:0] cob_cur_ext;
   logic [TW+9:0] total_ext;
   logic [TW+9:0] total_cur_ext;

   // Class count in use: zero counts as one, anything above the store's size is
   // held at the store's size.
   always_comb begin
      if (ncls_ff == 4'd0) begin
         m_eff = cff_pkg::CLASSES_W'(1);
      end else if (cff_pkg::CLASSES_W'(ncls_ff) > cff_pkg::CLASSES_W'(MAX_CLASSES)) begin
         m_eff = cff_pkg::CLASSES_W'(MAX_CLASSES);
      end else begin
         m_eff = cff_pkg::CLASSES_W'(ncls_ff);
      end
   end

   // The unused mode code behaves as plain harmonic mode.
   assign mode_var = (mode_ff == cff_pkg::MODE_VARIABLE);
   assign mode_bin = (mode_ff == cff_pkg::MODE_BINARY);

   assign busy   = (state_ff != cff_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign reject = (req_item_size == 10'd0) || (req_item_size > cap_ff);

   cff_class_sel #(
      .CW (CW)
   ) u_class_sel (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .advance     (state_ff == cff_pkg::ST_SEL),
      .item_size   (size_ff),
      .binary_mode (mode_bin),
      .classes     (m_eff),
      .capacity    (cap_ff),
      .done        (sel_done),
      .class_id    (sel_class)
   );

   // The scan issues one read a cycle; the word read for bin k is judged in the
   // cycle after. The write-back of a placement lands before the next word can
   // issue any read, as that word must first pass the idle and class search
   // states, so no forwarding path is needed.
   assign issue   = (state_ff == cff_pkg::ST_SCAN) && (rd_k_ff < KCW'(MAX_BINS));
   assign rd_addr = AW'(cls_ff) * AW'(MAX_BINS) + AW'(rd_k_ff[KW-1:0]);
   assign ev_addr = AW'(cls_ff) * AW'(MAX_BINS) + AW'(ev_k_ff);

   // A bin takes the item when the sum fits and, in variable harmonic mode, it
   // holds fewer items than its class allows; otherwise the scan moves on.
   always_comb begin
      sum      = 11'(rd_entry.fill) + 11'(size_ff);
      fits     = (sum <= 11'(cap_ff)) &&
                 !(mode_var && (rd_entry.count >=
                   10'(m_eff - cff_pkg::CLASSES_W'(cls_ff))));
      found    = (state_ff == cff_pkg::ST_SCAN) && ev_valid_ff && fits;
      last_bin = ev_valid_ff && (ev_k_ff == KW'(MAX_BINS - 1));
      opened   = (rd_entry.count == '0);
      cob_new  = cob_ff[cls_ff] + BW'(opened);
      total_new = total_ff + TW'(opened);
      wr_entry.fill  = sum[9:0];
      wr_entry.count = rd_entry.count + 10'd1;
      wr_en    = (state_ff == cff_pkg::ST_CLEAR) || found;
      wr_addr  = (state_ff == cff_pkg::ST_CLEAR) ? clr_addr_ff : ev_addr;
      if (state_ff == cff_pkg::ST_CLEAR) begin
         wr_entry = '0;
      end
      cls_ext       = {3'b000, cls_ff};
      bin_ext       = {6'b000000, ev_k_ff};
      cob_ext       = {7'b0000000, cob_new};
      cob_cur_ext   = {7'b0000000, cob_ff[cls_ff]};
      total_ext     = {10'b0000000000, total_new};
      total_cur_ext = {10'b0000000000, total_ff};
   end

   cff_bin_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_bin_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      mode_in     = mode_ff;
      ncls_in     = ncls_ff;
      cap_in      = cap_ff;
      size_in     = size_ff;
      cls_in      = cls_ff;
      rd_k_in     = rd_k_ff;
      ev_valid_in = 1'b0;
      ev_k_in     = ev_k_ff;
      cob_in      = cob_ff;
      total_in    = total_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      rcls_in     = rcls_ff;
      rbin_in     = rbin_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      opened_in   = opened_ff;
      rcob_in     = rcob_ff;
      rtotal_in   = rtotal_ff;

      // The user keeps register writes to idle or clearing; nothing enforces it.
      if (csr_we) begin
         case (csr_index)
            cff_pkg::CSR_PACK_MODE:    mode_in = csr_wdata[1:0];
            cff_pkg::CSR_NUM_CLASSES:  ncls_in = csr_wdata[3:0];
            cff_pkg::CSR_BIN_CAPACITY: cap_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         cff_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = cff_pkg::ST_IDLE;
            end
         end
         cff_pkg::ST_IDLE: begin
            if (accept) begin
               size_in = req_item_size;
               if (reject) begin
                  strobe_in = 1'b1;
                  status_in = cff_pkg::STATUS_REJECTED;
                  rcls_in   = '0;
                  rbin_in   = '0;
                  slot_in   = '0;
                  fill_in   = '0;
                  opened_in = 1'b0;
                  rcob_in   = '0;
                  rtotal_in = total_cur_ext[9:0];
               end else begin
                  state_in = cff_pkg::ST_SEL;
               end
            end
         end
         cff_pkg::ST_SEL: begin
            if (sel_done) begin
               cls_in   = sel_class;
               rd_k_in  = '0;
               state_in = cff_pkg::ST_SCAN;
            end
         end
         cff_pkg::ST_SCAN: begin
            ev_valid_in = issue;
            ev_k_in     = rd_k_ff[KW-1:0];
            if (issue) begin
               rd_k_in = rd_k_ff + KCW'(1);
            end
            if (found) begin
               cob_in[cls_ff] = cob_new;
               total_in  = total_new;
               strobe_in = 1'b1;
               status_in = cff_pkg::STATUS_PLACED;
               rcls_in   = cls_ext[2:0];
               rbin_in   = bin_ext[5:0];
               slot_in   = rd_entry.count;
               fill_in   = sum[9:0];
               opened_in = opened;
               rcob_in   = cob_ext[6:0];
               rtotal_in = total_ext[9:0];
               ev_valid_in = 1'b0;
               state_in  = cff_pkg::ST_IDLE;
            end else if (last_bin) begin
               strobe_in = 1'b1;
               status_in = cff_pkg::STATUS_FULL;
               rcls_in   = cls_ext[2:0];
               rbin_in   = '0;
               slot_in   = '0;
               fill_in   = '0;
               opened_in = 1'b0;
               rcob_in   = cob_cur_ext[6:0];
               rtotal_in = total_cur_ext[9:0];
               ev_valid_in = 1'b0;
               state_in  = cff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cff_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cff_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         mode_ff     <= cff_pkg::MODE_HARMONIC;
         ncls_ff     <= 4'd4;
         cap_ff      <= 10'd100;
         rd_k_ff     <= '0;
         ev_valid_ff <= 1'b0;
         total_ff    <= '0;
         strobe_ff   <= 1'b0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            cob_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         mode_ff     <= mode_in;
         ncls_ff     <= ncls_in;
         cap_ff      <= cap_in;
         rd_k_ff     <= rd_k_in;
         ev_valid_ff <= ev_valid_in;
         total_ff    <= total_in;
         strobe_ff   <= strobe_in;
         cob_ff      <= cob_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      cls_ff    <= cls_in;
      ev_k_ff   <= ev_k_in;
      status_ff <= status_in;
      rcls_ff   <= rcls_in;
      rbin_ff   <= rbin_in;
      slot_ff   <= slot_in;
      fill_ff   <= fill_in;
      opened_ff <= opened_in;
      rcob_ff   <= rcob_in;
      rtotal_ff <= rtotal_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_class_index   = rcls_ff;
   assign rsp_bin_index     = rbin_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_fill_after    = fill_ff;
   assign rsp_opened_new    = opened_ff;
   assign rsp_bins_in_class = rcob_ff;
   assign rsp_bins_total    = rtotal_ff;

endmodule
